[design/k_smallest_with_payload_macros.svh]
// Assertion macros shared by the k-smallest selection modules.
`ifndef K_SMALLEST_WITH_PAYLOAD_MACROS_SVH
`define K_SMALLEST_WITH_PAYLOAD_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define KSWP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define KSWP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/kswp_pkg.sv]
// Shared constants, a type and a function for the k-smallest selection block.
package kswp_pkg;

  localparam int MAX_KEPT_DEF = 16;
  localparam int RANK_LIMIT   = 16;
  localparam int DATA_W       = 32;
  localparam int RANK_W       = 4;
  localparam int KEEP_W       = 5;
  localparam int CNT_W        = 5;

  localparam logic [KEEP_W-1:0] KEEP_RESET = KEEP_W'(16);

  typedef struct packed {
    logic             load;
    logic [CNT_W-1:0] count;
  } dump_ctl_t;

  // Saturate the programmed keep count to 1 .. kc.
  function automatic logic [CNT_W-1:0] keep_clamp(input logic [KEEP_W-1:0] keep,
                                                  input logic [CNT_W-1:0] kc);
    logic [CNT_W-1:0] k;
    k = CNT_W'(keep);
    if (k == '0) k = CNT_W'(1);
    if (k > kc) k = kc;
    return k;
  endfunction

endpackage

[design/kswp_insert.sv]
// Input stage, sorted store and combinational insertion network.
`include "k_smallest_with_payload_macros.svh"
module kswp_insert #(
  parameter int MAX_KEPT = kswp_pkg::MAX_KEPT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [kswp_pkg::DATA_W-1:0]  in_sample_value,
  input  logic signed [kswp_pkg::DATA_W-1:0]  in_sample_payload,
  input  logic                                in_end_of_set,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kswp_pkg::KEEP_W-1:0]         cfg_keep_count,
  input  logic                                dump_free,
  output kswp_pkg::dump_ctl_t                 dump_ctl,
  output logic signed [kswp_pkg::DATA_W-1:0]  snap_val [(MAX_KEPT < kswp_pkg::RANK_LIMIT) ?
                                                        MAX_KEPT : kswp_pkg::RANK_LIMIT],
  output logic signed [kswp_pkg::DATA_W-1:0]  snap_pay [(MAX_KEPT < kswp_pkg::RANK_LIMIT) ?
                                                        MAX_KEPT : kswp_pkg::RANK_LIMIT]
);
  import kswp_pkg::*;

  localparam int KC = (MAX_KEPT < RANK_LIMIT) ? MAX_KEPT : RANK_LIMIT;
  localparam logic [CNT_W-1:0] KC_W = CNT_W'(KC);

  logic                     s_vld_r;
  logic signed [DATA_W-1:0] s_val_r;
  logic signed [DATA_W-1:0] s_pay_r;
  logic                     s_last_r;
  logic                     s_fire;
  logic                     in_acc;

  logic [KEEP_W-1:0]        keep_r;
  logic [CNT_W-1:0]         held_r;
  logic [CNT_W-1:0]         held_nxt;
  logic signed [DATA_W-1:0] val_r   [KC];
  logic signed [DATA_W-1:0] pay_r   [KC];
  logic signed [DATA_W-1:0] val_nxt [KC];
  logic signed [DATA_W-1:0] pay_nxt [KC];

  logic [CNT_W-1:0] k_eff;
  logic [CNT_W-1:0] held;
  logic [CNT_W-1:0] held_ins;
  logic [KC-1:0]    ge;
  logic [KC-1:0]    in_k;
  logic             ins;

  assign k_eff     = keep_clamp(keep_r, KC_W);
  assign cfg_ready = 1'b1;

  // A flagged word waits in the stage until the dump buffer can take the snapshot.
  assign s_fire   = s_vld_r && !(s_last_r && !dump_free);
  assign in_stall = s_vld_r && !s_fire;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    held = (held_r < k_eff) ? held_r : k_eff;
    for (int j = 0; j < KC; j++) begin
      // Slots at or past the fill level act as larger than any value.
      ge[j]   = ((CNT_W'(j) < held) && (val_r[j] > s_val_r)) || (CNT_W'(j) >= held);
      in_k[j] = CNT_W'(j) < k_eff;
    end
    ins      = |(ge & in_k);
    held_ins = (held < k_eff) ? held + CNT_W'(1) : k_eff;

    val_nxt[0] = (ins && ge[0]) ? s_val_r : val_r[0];
    pay_nxt[0] = (ins && ge[0]) ? s_pay_r : pay_r[0];
    for (int j = 1; j < KC; j++) begin
      if (ins && ge[j]) begin
        val_nxt[j] = ge[j-1] ? val_r[j-1] : s_val_r;
        pay_nxt[j] = ge[j-1] ? pay_r[j-1] : s_pay_r;
      end else begin
        val_nxt[j] = val_r[j];
        pay_nxt[j] = pay_r[j];
      end
    end

    held_nxt = held_r;
    if (s_fire) begin
      if (s_last_r) held_nxt = '0;
      else if (ins) held_nxt = held_ins;
      else held_nxt = held;
    end else if (cfg_valid) begin
      held_nxt = (held_r < keep_clamp(cfg_keep_count, KC_W)) ?
                 held_r : keep_clamp(cfg_keep_count, KC_W);
    end
  end

  assign dump_ctl.load  = s_fire && s_last_r;
  assign dump_ctl.count = ins ? held_ins : held;
  assign snap_val = val_nxt;
  assign snap_pay = pay_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
      keep_r  <= KEEP_RESET;
      held_r  <= '0;
    end else begin
      if (in_acc) s_vld_r <= 1'b1;
      else if (s_fire) s_vld_r <= 1'b0;
      if (cfg_valid && cfg_ready) keep_r <= cfg_keep_count;
      held_r <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_val_r  <= in_sample_value;
      s_pay_r  <= in_sample_payload;
      s_last_r <= in_end_of_set;
    end
    if (s_fire) begin
      val_r <= val_nxt;
      pay_r <= pay_nxt;
    end
  end

  `KSWP_ASSERT_NOW(a_held_le_k, clk, rst_n, 1'b1, held_r <= KC_W, "fill level beyond depth")
  `KSWP_ASSERT_NOW(a_stall_only_last, clk, rst_n, in_stall, s_vld_r && s_last_r && !dump_free,
                   "input stalled without a pending dump")
  `KSWP_ASSERT_NEXT(a_clear_after_last, clk, rst_n, s_fire && s_last_r, held_r == '0,
                    "store not emptied after flagged word")

endmodule

[design/kswp_dump.sv]
// Dump buffer: holds one snapshot of the sorted store and shifts it out by rank.
`include "k_smallest_with_payload_macros.svh"
module kswp_dump #(
  parameter int MAX_KEPT = kswp_pkg::MAX_KEPT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  kswp_pkg::dump_ctl_t                 dump_ctl,
  input  logic signed [kswp_pkg::DATA_W-1:0]  snap_val [(MAX_KEPT < kswp_pkg::RANK_LIMIT) ?
                                                        MAX_KEPT : kswp_pkg::RANK_LIMIT],
  input  logic signed [kswp_pkg::DATA_W-1:0]  snap_pay [(MAX_KEPT < kswp_pkg::RANK_LIMIT) ?
                                                        MAX_KEPT : kswp_pkg::RANK_LIMIT],
  output logic                                dump_free,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kswp_pkg::RANK_W-1:0]         out_rank,
  output logic signed [kswp_pkg::DATA_W-1:0]  out_kept_value,
  output logic signed [kswp_pkg::DATA_W-1:0]  out_kept_payload,
  output logic                                out_last_of_dump
);
  import kswp_pkg::*;

  localparam int KC = (MAX_KEPT < RANK_LIMIT) ? MAX_KEPT : RANK_LIMIT;
  localparam logic [CNT_W-1:0] KC_W = CNT_W'(KC);

  logic [CNT_W-1:0]         cnt_r;
  logic [RANK_W-1:0]        rank_r;
  logic signed [DATA_W-1:0] val_r [KC];
  logic signed [DATA_W-1:0] pay_r [KC];
  logic                     pop;

  assign out_valid        = cnt_r != '0;
  assign pop              = out_valid && !out_stall;
  assign dump_free        = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && !out_stall);
  assign out_rank         = rank_r;
  assign out_kept_value   = val_r[0];
  assign out_kept_payload = pay_r[0];
  assign out_last_of_dump = cnt_r == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      rank_r <= '0;
    end else if (dump_ctl.load) begin
      cnt_r  <= dump_ctl.count;
      rank_r <= '0;
    end else if (pop) begin
      cnt_r  <= cnt_r - CNT_W'(1);
      rank_r <= rank_r + RANK_W'(1);
    end
  end

  // Advance the snapshot toward slot 0 on every taken word.
  always_ff @(posedge clk) begin
    if (dump_ctl.load) begin
      val_r <= snap_val;
      pay_r <= snap_pay;
    end else if (pop) begin
      for (int i = 0; i < KC - 1; i++) begin
        val_r[i] <= val_r[i+1];
        pay_r[i] <= pay_r[i+1];
      end
    end
  end

  `KSWP_ASSERT_NOW(a_load_when_free, clk, rst_n, dump_ctl.load, dump_free,
                   "snapshot loaded over a pending dump")
  `KSWP_ASSERT_NEXT(a_valid_after_load, clk, rst_n, dump_ctl.load && (dump_ctl.count != '0),
                    out_valid && (out_rank == '0), "dump did not start at rank zero")
  `KSWP_ASSERT_NOW(a_cnt_le_k, clk, rst_n, 1'b1, cnt_r <= KC_W, "dump count beyond depth")

endmodule

[design/k_smallest_with_payload.sv]
// Top level of the k-smallest selection block with payloads.
//
//  channel   direction  handshake            words
//  in_       sink       in_valid/in_stall    value, payload, end_of_set
//  out_      source     out_valid/out_stall  rank, kept value, kept payload, last
//  cfg_      sink       cfg_valid/cfg_ready  keep_count
//
// One input word per cycle unless stalled: the parallel compare and shift over
// the kept entries is done on the word in the input stage and stored as it
// leaves. A flagged word snapshots the store into the dump buffer, which drains
// one word per cycle unless out_stall; the input stalls only if a second flagged
// word reaches the stage while that dump is still draining. Reset is synchronous:
// store empty, keep_count 16, no dump pending.
module k_smallest_with_payload #(
  parameter int MAX_KEPT = kswp_pkg::MAX_KEPT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [kswp_pkg::DATA_W-1:0]  in_sample_value,
  input  logic signed [kswp_pkg::DATA_W-1:0]  in_sample_payload,
  input  logic                                in_end_of_set,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [kswp_pkg::RANK_W-1:0]         out_rank,
  output logic signed [kswp_pkg::DATA_W-1:0]  out_kept_value,
  output logic signed [kswp_pkg::DATA_W-1:0]  out_kept_payload,
  output logic                                out_last_of_dump,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [kswp_pkg::KEEP_W-1:0]         cfg_keep_count
);
  import kswp_pkg::*;

  localparam int KC = (MAX_KEPT < RANK_LIMIT) ? MAX_KEPT : RANK_LIMIT;

  dump_ctl_t                dump_ctl;
  logic                     dump_free;
  logic signed [DATA_W-1:0] snap_val [KC];
  logic signed [DATA_W-1:0] snap_pay [KC];

  kswp_insert #(.MAX_KEPT(MAX_KEPT)) u_insert (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample_value  (in_sample_value),
    .in_sample_payload(in_sample_payload),
    .in_end_of_set    (in_end_of_set),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_keep_count   (cfg_keep_count),
    .dump_free        (dump_free),
    .dump_ctl         (dump_ctl),
    .snap_val         (snap_val),
    .snap_pay         (snap_pay)
  );

  kswp_dump #(.MAX_KEPT(MAX_KEPT)) u_dump (
    .clk              (clk),
    .rst_n            (rst_n),
    .dump_ctl         (dump_ctl),
    .snap_val         (snap_val),
    .snap_pay         (snap_pay),
    .dump_free        (dump_free),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_rank         (out_rank),
    .out_kept_value   (out_kept_value),
    .out_kept_payload (out_kept_payload),
    .out_last_of_dump (out_last_of_dump)
  );

endmodule
